/* rtl/ils_pkg.sv */
// ils_pkg: shared types and constants for the indexed list store
// operation codes, status codes, datapath command and flag structs
// no dependencies
package ils_pkg;

    localparam int OP_W   = 4;
    localparam int POS_W  = 9;
    localparam int NLEN_W = 9;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_READ   = 4'd0,
        OP_WRITE  = 4'd1,
        OP_INSERT = 4'd2,
        OP_ERASE  = 4'd3,
        OP_PUSH   = 4'd4,
        OP_POP    = 4'd5,
        OP_CLEAR  = 4'd6,
        OP_ASSIGN = 4'd7,
        OP_RESIZE = 4'd8,
        OP_FRONT  = 4'd9,
        OP_BACK   = 4'd10
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        AD_POS    = 3'd0,
        AD_PTR    = 3'd1,
        AD_PTR_DN = 3'd2,
        AD_PTR_UP = 3'd3,
        AD_ZERO   = 3'd4,
        AD_BACK   = 3'd5,
        AD_LEN    = 3'd6
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_VAL  = 2'd0,
        WD_Q    = 2'd1,
        WD_ZERO = 2'd2
    } t_wdata_sel;

    typedef enum logic [2:0] {
        PTR_HOLD = 3'd0,
        PTR_LEN  = 3'd1,
        PTR_POS  = 3'd2,
        PTR_ZERO = 3'd3,
        PTR_INC  = 3'd4,
        PTR_DEC  = 3'd5
    } t_ptr_op;

    typedef enum logic [2:0] {
        LEN_HOLD = 3'd0,
        LEN_INC  = 3'd1,
        LEN_DEC  = 3'd2,
        LEN_ZERO = 3'd3,
        LEN_N    = 3'd4
    } t_len_op;

    typedef struct packed {
        logic       latch;
        logic       ram_we;
        t_addr_sel  addr_sel;
        t_wdata_sel wdata_sel;
        t_ptr_op    ptr_op;
        t_len_op    len_op;
        logic       st_we;
        t_status    st_code;
        logic       rd_cap;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            pos_lt_len;
        logic            pos_gt_len;
        logic            len_full;
        logic            len_zero;
        logic            n_gt_depth;
        logic            ptr_eq_pos;
        logic            ptr_last;
        logic            ptr_ge_n;
        logic            out_free;
    } t_flags;

endpackage

/* rtl/indexed_list_store.sv */
// indexed_list_store: ordered list of signed words with insert, erase, fill and resize
// sequence: accept, exec step, done step; read, front and back add a ram read step before done,
// insert/erase add a read and write step per moved entry, assign/resize a fill step per slot
// throughput: one operation at a time, next beat taken the cycle after the result loads
// reset: synchronous active low, list empty; entries undefined until written, no clearing pass
// depends on ils_pkg, ils_ctrl, ils_datapath, ils_ram
module indexed_list_store
    import ils_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // operation beat in
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic [NLEN_W-1:0]        i_new_length,
    input  logic signed [DATA_W-1:0] i_data_value,
    // result beat out
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [NLEN_W-1:0]        o_length_now,
    output logic                     o_is_empty,
    output logic [STAT_W-1:0]        o_status
);

    // controller sequences each operation, datapath holds the list
    t_cmd   cmd;
    t_flags flags;

    // sequencer: takes a beat in idle, walks shift and fill loops, hands off the result beat;
    // a finished result may still wait in the output register while the next beat comes in
    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_flags    (flags),
        .o_cmd      (cmd)
    );

    // entry ram, length, shift pointer and output register
    ils_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_operation  (i_operation),
        .i_position   (i_position),
        .i_new_length (i_new_length),
        .i_data_value (i_data_value),
        .i_cmd        (cmd),
        .o_flags      (flags),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_read_value (o_read_value),
        .o_length_now (o_length_now),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status)
    );

endmodule

/* rtl/ils_ram.sv */
// ils_ram: generic single-port ram, read-first, registered read data
// no dependencies
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_addr];
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/ils_datapath.sv */
// ils_datapath: operand latches, length and pointer registers, entry ram, result register
// depends on ils_pkg and ils_ram
module ils_datapath
    import ils_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [OP_W-1:0]          i_operation,
    input  logic [POS_W-1:0]         i_position,
    input  logic [NLEN_W-1:0]        i_new_length,
    input  logic signed [DATA_W-1:0] i_data_value,
    input  t_cmd                     i_cmd,
    output t_flags                   o_flags,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [DATA_W-1:0] o_read_value,
    output logic [NLEN_W-1:0]        o_length_now,
    output logic                     o_is_empty,
    output logic [STAT_W-1:0]        o_status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW > POS_W) ? LW : POS_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [OP_W-1:0]   r_op;
    logic [POS_W-1:0]  r_pos;
    logic [NLEN_W-1:0] r_n;
    logic [DATA_W-1:0] r_val;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_ptr, n_ptr;
    logic [DATA_W-1:0] r_rd;
    t_status           r_st;

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_rd;
    logic [NLEN_W-1:0] r_out_len;
    logic              r_out_empty;
    t_status           r_out_st;

    logic [CW-1:0]     pos_x, n_x, len_x, ptr_x;
    logic [LW-1:0]     ptr_dn, ptr_up, len_dn;
    logic [AW-1:0]     ram_addr;
    logic [DATA_W-1:0] ram_wdata, ram_q;

    assign pos_x  = CW'(r_pos);
    assign n_x    = CW'(r_n);
    assign len_x  = CW'(r_len);
    assign ptr_x  = CW'(r_ptr);
    assign ptr_dn = r_ptr - LW'(1);
    assign ptr_up = r_ptr + LW'(1);
    assign len_dn = r_len - LW'(1);

    // flags for the controller
    always_comb begin
        o_flags.op         = r_op;
        o_flags.pos_lt_len = (pos_x < len_x);
        o_flags.pos_gt_len = (pos_x > len_x);
        o_flags.len_full   = (len_x == DEPTH_C);
        o_flags.len_zero   = (r_len == '0);
        o_flags.n_gt_depth = (n_x > DEPTH_C);
        o_flags.ptr_eq_pos = (ptr_x == pos_x);
        o_flags.ptr_last   = ((ptr_x + CW'(1)) == len_x);
        o_flags.ptr_ge_n   = (ptr_x >= n_x);
        o_flags.out_free   = !r_out_valid || i_out_ready;
    end

    always_comb begin
        case (i_cmd.addr_sel)
            AD_POS:    ram_addr = pos_x[AW-1:0];
            AD_PTR:    ram_addr = ptr_x[AW-1:0];
            AD_PTR_DN: ram_addr = ptr_dn[AW-1:0];
            AD_PTR_UP: ram_addr = ptr_up[AW-1:0];
            AD_BACK:   ram_addr = len_dn[AW-1:0];
            AD_LEN:    ram_addr = len_x[AW-1:0];
            default:   ram_addr = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.wdata_sel)
            WD_VAL:  ram_wdata = r_val;
            WD_Q:    ram_wdata = ram_q;
            default: ram_wdata = '0;
        endcase
    end

    always_comb begin
        case (i_cmd.ptr_op)
            PTR_LEN:  n_ptr = r_len;
            PTR_POS:  n_ptr = pos_x[LW-1:0];
            PTR_ZERO: n_ptr = '0;
            PTR_INC:  n_ptr = ptr_up;
            PTR_DEC:  n_ptr = ptr_dn;
            default:  n_ptr = r_ptr;
        endcase
    end

    always_comb begin
        case (i_cmd.len_op)
            LEN_INC:  n_len = r_len + LW'(1);
            LEN_DEC:  n_len = len_dn;
            LEN_ZERO: n_len = '0;
            LEN_N:    n_len = n_x[LW-1:0];
            default:  n_len = r_len;
        endcase
    end

    ils_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    // operand latches and working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op  <= i_operation;
            r_pos <= i_position;
            r_n   <= i_new_length;
            r_val <= i_data_value;
            r_rd  <= '0;
            r_st  <= ST_OK;
        end else begin
            if (i_cmd.rd_cap) begin
                r_rd <= ram_q;
            end
            if (i_cmd.st_we) begin
                r_st <= i_cmd.st_code;
            end
        end
        r_ptr <= n_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rd    <= r_rd;
            r_out_len   <= len_x[NLEN_W-1:0];
            r_out_empty <= (r_len == '0);
            r_out_st    <= r_st;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_value = r_out_rd;
    assign o_length_now = r_out_len;
    assign o_is_empty   = r_out_empty;
    assign o_status     = r_out_st;

endmodule

/* rtl/ils_ctrl.sv */
// ils_ctrl: operation sequencer for the indexed list store
// depends on ils_pkg
module ils_ctrl
    import ils_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    input  t_flags i_flags,
    output t_cmd   o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_EXEC    = 9'b000000010,
        S_READ    = 9'b000000100,
        S_SHUP_RD = 9'b000001000,
        S_SHUP_WR = 9'b000010000,
        S_SHDN_RD = 9'b000100000,
        S_SHDN_WR = 9'b001000000,
        S_FILL    = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (t_op'(i_flags.op))
                    OP_READ: begin
                        if (i_flags.pos_lt_len) begin
                            o_cmd.addr_sel = AD_POS;
                            n_state        = S_READ;
                        end else begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_RANGE;
                        end
                    end
                    OP_WRITE: begin
                        if (i_flags.pos_lt_len) begin
                            o_cmd.ram_we    = 1'b1;
                            o_cmd.addr_sel  = AD_POS;
                            o_cmd.wdata_sel = WD_VAL;
                        end else begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_RANGE;
                        end
                    end
                    OP_INSERT: begin
                        if (i_flags.pos_gt_len) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_RANGE;
                        end else if (i_flags.len_full) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.ptr_op = PTR_LEN;
                            n_state      = S_SHUP_RD;
                        end
                    end
                    OP_ERASE: begin
                        if (!i_flags.pos_lt_len) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_RANGE;
                        end else begin
                            o_cmd.ptr_op = PTR_POS;
                            n_state      = S_SHDN_RD;
                        end
                    end
                    OP_PUSH: begin
                        if (i_flags.len_full) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.ram_we    = 1'b1;
                            o_cmd.addr_sel  = AD_LEN;
                            o_cmd.wdata_sel = WD_VAL;
                            o_cmd.len_op    = LEN_INC;
                        end
                    end
                    OP_POP: begin
                        if (i_flags.len_zero) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                        end else begin
                            o_cmd.len_op = LEN_DEC;
                        end
                    end
                    OP_CLEAR: begin
                        o_cmd.len_op = LEN_ZERO;
                    end
                    OP_ASSIGN: begin
                        if (i_flags.n_gt_depth) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.ptr_op = PTR_ZERO;
                            n_state      = S_FILL;
                        end
                    end
                    OP_RESIZE: begin
                        if (i_flags.n_gt_depth) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_FULL;
                        end else begin
                            o_cmd.ptr_op = PTR_LEN;
                            n_state      = S_FILL;
                        end
                    end
                    OP_FRONT: begin
                        if (i_flags.len_zero) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                        end else begin
                            o_cmd.addr_sel = AD_ZERO;
                            n_state        = S_READ;
                        end
                    end
                    OP_BACK: begin
                        if (i_flags.len_zero) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = ST_EMPTY;
                        end else begin
                            o_cmd.addr_sel = AD_BACK;
                            n_state        = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_READ: begin
                o_cmd.rd_cap = 1'b1;
                n_state      = S_DONE;
            end
            // insert: move entries up from the top down to the insert point
            S_SHUP_RD: begin
                if (i_flags.ptr_eq_pos) begin
                    o_cmd.ram_we    = 1'b1;
                    o_cmd.addr_sel  = AD_PTR;
                    o_cmd.wdata_sel = WD_VAL;
                    o_cmd.len_op    = LEN_INC;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.addr_sel = AD_PTR_DN;
                    n_state        = S_SHUP_WR;
                end
            end
            S_SHUP_WR: begin
                o_cmd.ram_we    = 1'b1;
                o_cmd.addr_sel  = AD_PTR;
                o_cmd.wdata_sel = WD_Q;
                o_cmd.ptr_op    = PTR_DEC;
                n_state         = S_SHUP_RD;
            end
            // erase: move entries down, then zero the vacated top slot
            S_SHDN_RD: begin
                if (i_flags.ptr_last) begin
                    o_cmd.ram_we    = 1'b1;
                    o_cmd.addr_sel  = AD_PTR;
                    o_cmd.wdata_sel = WD_ZERO;
                    o_cmd.len_op    = LEN_DEC;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.addr_sel = AD_PTR_UP;
                    n_state        = S_SHDN_WR;
                end
            end
            S_SHDN_WR: begin
                o_cmd.ram_we    = 1'b1;
                o_cmd.addr_sel  = AD_PTR;
                o_cmd.wdata_sel = WD_Q;
                o_cmd.ptr_op    = PTR_INC;
                n_state         = S_SHDN_RD;
            end
            S_FILL: begin
                if (i_flags.ptr_ge_n) begin
                    o_cmd.len_op = LEN_N;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.ram_we    = 1'b1;
                    o_cmd.addr_sel  = AD_PTR;
                    o_cmd.wdata_sel = WD_VAL;
                    o_cmd.ptr_op    = PTR_INC;
                end
            end
            S_DONE: begin
                if (i_flags.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
